// ===== hdl/table_driven_block_decrypt_unit_defines.svh =====
// Assertion macros for the table-driven block decrypt unit.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef TABLE_DRIVEN_BLOCK_DECRYPT_UNIT_DEFINES_SVH
`define TABLE_DRIVEN_BLOCK_DECRYPT_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TDBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TDBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tdbd_pkg.sv =====
// ----------------------------------------------------------------------------
// tdbd_pkg
// Types, transaction kind codes and byte selection for the block decrypt unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tdbd_pkg;

    typedef enum logic [1:0] {
        KIND_TABLE   = 2'd0,
        KIND_KEY     = 2'd1,
        KIND_DECRYPT = 2'd2,
        KIND_CHAIN   = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef logic [31:0]        word_t;
    typedef word_t [15:0]       tbl_words_t;
    typedef word_t [3:0]        key_words_t;
    typedef logic [127:0]       block_t;
    typedef logic [15:0][7:0]   bytes_t;

    // Source byte for each table in a shifted-row round
    localparam logic [3:0] SHIFT_PICK [16] = '{
        4'd0, 4'd7, 4'd10, 4'd13,
        4'd1, 4'd4, 4'd11, 4'd14,
        4'd2, 4'd5, 4'd8,  4'd15,
        4'd3, 4'd6, 4'd9,  4'd12
    };

    // Table index bytes for one round, straight or shifted-row order
    function automatic bytes_t pick_bytes(block_t s, logic shifted);
        bytes_t     b;
        logic [3:0] src;
        for (int i = 0; i < 16; i++)
        begin
            src  = shifted ? SHIFT_PICK[i] : 4'(i);
            b[i] = s[8*src +: 8];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tdbd_if.sv =====
// ----------------------------------------------------------------------------
// tdbd_in_if / tdbd_out_if
// Valid/ready channels carrying input and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdbd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [4:0]  round_index;
    logic [3:0]  lane;
    logic [7:0]  entry;
    logic [31:0] word;
    logic [63:0] block_lo;
    logic [63:0] block_hi;

    modport source (output valid, kind, round_index, lane, entry, word, block_lo, block_hi,
                    input ready);
    modport sink   (input valid, kind, round_index, lane, entry, word, block_lo, block_hi,
                    output ready);
endinterface

interface tdbd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_lo;
    logic [63:0] plain_hi;

    modport source (output valid, plain_lo, plain_hi, input ready);
    modport sink   (input valid, plain_lo, plain_hi, output ready);
endinterface

`default_nettype wire

// ===== hdl/tdbd_ram.sv =====
// ----------------------------------------------------------------------------
// tdbd_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbd_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/tdbd_round.sv =====
// ----------------------------------------------------------------------------
// tdbd_round
// Round combine: each state word is four table words XOR the round key.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbd_round (
    input  wire tdbd_pkg::tbl_words_t tbl,
    input  wire tdbd_pkg::key_words_t key,
    output tdbd_pkg::block_t          state
);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            state[32*k +: 32] = key[k] ^ tbl[4*k] ^ tbl[4*k+1] ^ tbl[4*k+2] ^ tbl[4*k+3];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/table_driven_block_decrypt_unit.sv =====
// ----------------------------------------------------------------------------
// table_driven_block_decrypt_unit
// Table-driven 128-bit block decryption, codebook or block chaining mode.
// ----------------------------------------------------------------------------
// Usage:
//   blk_in carries one transaction per valid/ready handshake. Kind table
//   writes one lookup word, kind key writes one round-key word, kind chain
//   loads the 128-bit chaining value; these take effect at the handshake and
//   give no result. Kind decrypt carries one ciphertext block.
//   blk_out returns one plaintext block per decrypt transaction, in order.
//   cfg_wr_en/cfg_wr_data write the chaining mode bit (1 = block chaining);
//   write it only while the unit is idle.
// Rounds:
//   A block steps one round per cycle: sixteen table banks
//   and four key banks are read together each cycle, and the read of round
//   r+1 is addressed from the combine of round r. The result register loads
//   from the combine of the last round; a new transaction is taken only
//   once the unit is back in idle, after the last block finishes.
// Reset:
//   Clears control state, the mode bit and the chaining value. Tables and
//   keys are undefined until written; no clearing pass is run.
// Stall:
//   The result register holds while blk_out is stalled; input is still taken.
//   A following block finishes its last round and waits until the register
//   frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "table_driven_block_decrypt_unit_defines.svh"

module table_driven_block_decrypt_unit #(
    parameter int ROUND_COUNT = 17
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data,
    tdbd_in_if.sink     blk_in,
    tdbd_out_if.source  blk_out
);

    localparam int             RW         = $clog2(ROUND_COUNT);
    localparam int             TAW        = RW + 8;
    localparam int             TDEPTH     = ROUND_COUNT * 256;
    localparam logic [5:0]     RC_LIMIT   = 6'(ROUND_COUNT);
    localparam logic [RW-1:0]  LAST_ROUND = RW'(ROUND_COUNT - 1);
    localparam logic [RW-1:0]  FIRST_SHIFT = RW'(2);

    // Control and payload registers
    tdbd_pkg::state_t  state_reg, state_next;
    logic [RW-1:0]     round_reg, round_next;
    logic              mode_reg;
    tdbd_pkg::block_t  chain_reg, chain_next;
    tdbd_pkg::block_t  cipher_reg;
    tdbd_pkg::block_t  plain_reg;
    logic              out_valid_reg, out_valid_next;

    // Memory access controls
    logic              in_fire;
    logic              in_range;
    logic              tbl_we;
    logic              key_we;
    logic              start;
    logic              finish;
    logic              rd_en;
    logic [RW-1:0]     rd_round;
    logic              rd_shift;
    tdbd_pkg::block_t  rd_src;
    tdbd_pkg::bytes_t  rd_bytes;
    logic [RW-1:0]     round_inc;
    logic              out_free;

    tdbd_pkg::tbl_words_t tbl_q;
    tdbd_pkg::key_words_t key_q;
    tdbd_pkg::block_t     round_out;
    tdbd_pkg::block_t     in_block;

    assign in_block  = {blk_in.block_hi, blk_in.block_lo};
    assign in_fire   = blk_in.valid && blk_in.ready;
    assign in_range  = {1'b0, blk_in.round_index} < RC_LIMIT;
    assign round_inc = round_reg + 1'b1;
    assign out_free  = !out_valid_reg || blk_out.ready;

    // ------------------------------------------------------------------
    // Sequencer: decode transactions in idle, step one round per cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        tbl_we     = 1'b0;
        key_we     = 1'b0;
        start      = 1'b0;
        finish     = 1'b0;
        rd_en      = 1'b0;
        rd_round   = '0;
        rd_shift   = 1'b0;
        rd_src     = in_block;
        chain_next = chain_reg;

        unique case (state_reg)
            tdbd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (tdbd_pkg::kind_t'(blk_in.kind))
                        tdbd_pkg::KIND_TABLE:
                        begin
                            tbl_we = in_range;
                        end
                        tdbd_pkg::KIND_KEY:
                        begin
                            key_we = in_range && (blk_in.lane[3:2] == 2'b00);
                        end
                        tdbd_pkg::KIND_CHAIN:
                        begin
                            chain_next = in_block;
                        end
                        tdbd_pkg::KIND_DECRYPT:
                        begin
                            // Issue the round 0 read straight from the payload
                            start      = 1'b1;
                            rd_en      = 1'b1;
                            round_next = '0;
                            state_next = tdbd_pkg::ST_RUN;
                        end
                    endcase
                end
            end
            tdbd_pkg::ST_RUN:
            begin
                rd_src = round_out;
                if (round_reg != LAST_ROUND)
                begin
                    // Advance: address the next round from this combine
                    rd_en      = 1'b1;
                    rd_round   = round_inc;
                    rd_shift   = (round_inc >= FIRST_SHIFT) && (round_inc < LAST_ROUND);
                    round_next = round_inc;
                end
                else if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = tdbd_pkg::ST_IDLE;
                    if (mode_reg)
                    begin
                        chain_next = cipher_reg;
                    end
                end
            end
        endcase
    end

    assign rd_bytes = tdbd_pkg::pick_bytes(rd_src, rd_shift);

    assign out_valid_next = finish ? 1'b1 : (blk_out.ready ? 1'b0 : out_valid_reg);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdbd_pkg::ST_IDLE;
            round_reg     <= '0;
            mode_reg      <= 1'b0;
            chain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    // Payload: hold the ciphertext for chaining, load the result on finish
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cipher_reg <= in_block;
        end
        if (finish)
        begin
            plain_reg <= round_out ^ (mode_reg ? chain_reg : '0);
        end
    end

    assign blk_in.ready     = (state_reg == tdbd_pkg::ST_IDLE);
    assign blk_out.valid    = out_valid_reg;
    assign blk_out.plain_lo = plain_reg[63:0];
    assign blk_out.plain_hi = plain_reg[127:64];

    // ------------------------------------------------------------------
    // Banked table memories: bank b holds table b of every round
    // ------------------------------------------------------------------
    for (genvar b = 0; b < 16; b++)
    begin : g_tbl
        tdbd_ram #(
            .DW    (32),
            .DEPTH (TDEPTH),
            .AW    (TAW)
        ) u_tbl (
            .clk   (clk),
            .we    (tbl_we && (blk_in.lane == 4'(b))),
            .waddr ({blk_in.round_index[RW-1:0], blk_in.entry}),
            .wdata (blk_in.word),
            .re    (rd_en),
            .raddr ({rd_round, rd_bytes[b]}),
            .rdata (tbl_q[b])
        );
    end

    // Round-key memories: bank k holds key word k of every round
    for (genvar k = 0; k < 4; k++)
    begin : g_key
        tdbd_ram #(
            .DW    (32),
            .DEPTH (ROUND_COUNT),
            .AW    (RW)
        ) u_key (
            .clk   (clk),
            .we    (key_we && (blk_in.lane[1:0] == 2'(k))),
            .waddr (blk_in.round_index[RW-1:0]),
            .wdata (blk_in.word),
            .re    (rd_en),
            .raddr (rd_round),
            .rdata (key_q[k])
        );
    end

    tdbd_round u_round (
        .tbl   (tbl_q),
        .key   (key_q),
        .state (round_out)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TDBD_ASSERT_NXT(a_start_round0, blk_in.valid && blk_in.ready && blk_in.kind == tdbd_pkg::KIND_DECRYPT, state_reg == tdbd_pkg::ST_RUN && round_reg == '0, "decrypt did not start at round 0")
    `TDBD_ASSERT_NXT(a_round_step, state_reg == tdbd_pkg::ST_RUN && round_reg != LAST_ROUND, round_reg == RW'($past(round_reg) + 1'b1), "round counter skipped")
    `TDBD_ASSERT_IMP(a_result_source, $rose(blk_out.valid), $past(state_reg == tdbd_pkg::ST_RUN && round_reg == LAST_ROUND), "result raised outside the last round")

endmodule

`default_nettype wire
